@@ design/signal_phase_dp_optimizer_macros.svh @@
// Assertion macros of the optimizer RTL.
// No dependencies; included by spdo_back, the file that carries assertions.
`ifndef SIGNAL_PHASE_DP_OPTIMIZER_MACROS_SVH
`define SIGNAL_PHASE_DP_OPTIMIZER_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define SPDO_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("spdo assertion failed");

// Next-cycle implication, disabled while reset is low.
`define SPDO_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("spdo assertion failed");

`endif

@@ design/spdo_pkg.sv @@
// Shared constants, types and helper functions of the signal phase optimizer.
// No dependencies; every other design file but the assertion macros header imports it.
package spdo_pkg;

    // Sizing of the horizon and the stage table.
    localparam int HORIZON    = 10;
    localparam int MAX_STAGES = 8;
    localparam int NPH        = 3;

    localparam int S_W    = $clog2(HORIZON + 1);
    localparam int IDX_W  = $clog2(HORIZON);
    localparam int J_W    = $clog2(MAX_STAGES);
    localparam int MEM_AW = J_W + S_W;
    localparam int MEM_DEPTH = 1 << MEM_AW;

    // Field widths.
    localparam int ARR_W = 8;
    localparam int PH_W  = 2;
    localparam int G_W   = 4;
    localparam int Q_W   = 12;
    localparam int V_W   = 16;

    // Accumulator widths.
    localparam int SUM_W  = ARR_W + S_W;
    localparam int WAIT_W = 2 * S_W;
    localparam int T_W    = ((Q_W > SUM_W) ? Q_W : SUM_W) + 1;
    localparam int TD_W   = Q_W + S_W + 1;
    localparam int ACC_W  = TD_W + 3;

    localparam logic [Q_W-1:0] Q_MAX = '1;
    localparam logic [V_W-1:0] V_MAX = '1;
    localparam logic [G_W-1:0] G_MAX = '1;

    // Load queue between front and back.
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    // Configuration port.
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_PHASE = 2'd0,
        CFG_INDEX_MODE  = 2'd1,
        CFG_MIN_GREEN   = 2'd2
    } t_cfg_idx;

    // Objective codes; any other code means total delay.
    localparam logic [1:0] MODE_MAX_QUEUE   = 2'd0;
    localparam logic [1:0] MODE_TOTAL_STOPS = 2'd1;

    localparam logic [PH_W-1:0] PH_A    = 2'd0;
    localparam logic [PH_W-1:0] PH_LAST = PH_W'(NPH - 1);

    typedef struct packed {
        logic [1:0] start_phase;
        logic [1:0] index_mode;
        logic [3:0] min_green;
    } t_cfg;

    // One classified load beat from front to back.
    typedef struct packed {
        logic [NPH-1:0][ARR_W-1:0] arr;
        logic [IDX_W-1:0]          idx;
        logic                      last;
    } t_load_beat;

    // One stage/state row of the DP table.
    typedef struct packed {
        logic [S_W-1:0]          choice;
        logic [V_W-1:0]          value;
        logic [NPH-1:0][Q_W-1:0] queue;
    } t_row;

    function automatic logic [PH_W-1:0] f_next_phase(input logic [PH_W-1:0] ph);
        return (ph >= PH_LAST) ? PH_A : PH_W'(ph + 1'b1);
    endfunction

    function automatic logic [PH_W-1:0] f_prev_phase(input logic [PH_W-1:0] ph);
        return (ph == PH_A) ? PH_LAST : PH_W'(ph - 1'b1);
    endfunction

endpackage

@@ design/spdo_ifs.sv @@
// Stream interfaces of the optimizer: arrival beats in, plan beats out.
// Depends on spdo_pkg.
interface spdo_in_if import spdo_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [ARR_W-1:0] arrivals_phase_a;
    logic [ARR_W-1:0] arrivals_phase_b;
    logic [ARR_W-1:0] arrivals_phase_c;

    modport source(output valid, arrivals_phase_a, arrivals_phase_b, arrivals_phase_c,
                   input ready);
    modport sink(input valid, arrivals_phase_a, arrivals_phase_b, arrivals_phase_c,
                 output ready);
endinterface

interface spdo_out_if import spdo_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [PH_W-1:0] plan_phase;
    logic [G_W-1:0]  green_length;
    logic            plan_last;
    logic            stage_limit_hit;

    modport source(output valid, plan_phase, green_length, plan_last, stage_limit_hit,
                   input ready);
    modport sink(input valid, plan_phase, green_length, plan_last, stage_limit_hit,
                 output ready);
endinterface

@@ design/spdo_front.sv @@
// Front end: accepts arrival beats and tags each with its horizon slot.
// Depends on spdo_pkg and spdo_in_if.
module spdo_front import spdo_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    spdo_in_if.sink    i_in,
    input  logic       i_full,
    output logic       o_push,
    output t_load_beat o_push_beat
);

    logic [IDX_W-1:0] r_load_count;
    logic [IDX_W-1:0] n_load_count;
    logic             w_last;

    // Accept whenever the load queue has room.
    assign i_in.ready = !i_full;
    assign o_push     = i_in.valid && !i_full;
    assign w_last     = (r_load_count == IDX_W'(HORIZON - 1));

    // Classify the beat: slot index and end of horizon.
    assign o_push_beat.arr  = {i_in.arrivals_phase_c, i_in.arrivals_phase_b,
                               i_in.arrivals_phase_a};
    assign o_push_beat.idx  = r_load_count;
    assign o_push_beat.last = w_last;

    assign n_load_count = w_last ? '0 : IDX_W'(r_load_count + 1'b1);

    // Slot counter wraps after the last step of the horizon.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_count <= '0;
        end else if (o_push) begin
            r_load_count <= n_load_count;
        end
    end

endmodule

@@ design/spdo_fifo.sv @@
// Short load queue between the front end and the DP engine.
// Depends on spdo_pkg.
module spdo_fifo import spdo_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_load_beat i_push_beat,
    output logic       o_full,
    input  logic       i_pop,
    output logic       o_empty,
    output t_load_beat o_pop_beat
);

    t_load_beat         r_entry [FIFO_DEPTH];
    logic [FIFO_PW-1:0] r_wr_ptr;
    logic [FIFO_PW-1:0] r_rd_ptr;
    logic [FIFO_CW-1:0] r_count;

    assign o_full     = (r_count == FIFO_CW'(FIFO_DEPTH));
    assign o_empty    = (r_count == '0);
    assign o_pop_beat = r_entry[r_rd_ptr];

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_push_beat;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == FIFO_PW'(FIFO_DEPTH - 1)) ? '0
                                                                   : FIFO_PW'(r_wr_ptr + 1'b1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == FIFO_PW'(FIFO_DEPTH - 1)) ? '0
                                                                   : FIFO_PW'(r_rd_ptr + 1'b1);
            end
            if (i_push && !i_pop) begin
                r_count <= FIFO_CW'(r_count + 1'b1);
            end else if (i_pop && !i_push) begin
                r_count <= FIFO_CW'(r_count - 1'b1);
            end
        end
    end

endmodule

@@ design/spdo_back.sv @@
// Back end: arrival store, staged DP sequencer, stage table and plan retrieval.
// Depends on spdo_pkg, spdo_out_if and the assertion macros header.
`include "signal_phase_dp_optimizer_macros.svh"

module spdo_back import spdo_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_empty,
    input  t_load_beat i_beat,
    output logic       o_pop,
    spdo_out_if.source o_out
);

    typedef enum logic [8:0] {
        ST_LOAD  = 9'b000000001,
        ST_CAND  = 9'b000000010,
        ST_ACC   = 9'b000000100,
        ST_EVAL  = 9'b000001000,
        ST_CMP   = 9'b000010000,
        ST_WRITE = 9'b000100000,
        ST_CHECK = 9'b001000000,
        ST_RRD   = 9'b010000000,
        ST_EMIT  = 9'b100000000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Arrival store, one row per time step, all three phases side by side.
    logic [NPH-1:0][ARR_W-1:0] r_store [HORIZON];

    // Stage table memory, addressed by stage and state.
    t_row              r_mem [MEM_DEPTH];
    t_row              r_rd;
    logic              w_rd_en;
    logic [MEM_AW-1:0] w_rd_addr;
    logic              w_wr_en;

    // Sequencer registers.
    logic [J_W-1:0]  r_j;
    logic [PH_W-1:0] r_ph;
    logic [S_W-1:0]  r_s;
    logic [S_W-1:0]  r_x;
    logic [S_W-1:0]  r_si;
    logic [S_W-1:0]  r_k;
    logic            r_first;
    logic            r_limit;
    logic [J_W-1:0]  r_jj;
    logic [PH_W-1:0] r_rph;

    // Candidate accumulators and evaluation results.
    logic [NPH-1:0][SUM_W-1:0]  r_ts;
    logic [NPH-1:0][WAIT_W-1:0] r_ws;
    logic [NPH-1:0][Q_W-1:0]    r_tq;
    logic [ACC_W-1:0]           r_delay;
    logic [ACC_W-1:0]           r_stops;
    logic [Q_W-1:0]             r_maxq;

    // Best candidate of the current state.
    logic [V_W-1:0]          r_bv;
    logic [S_W-1:0]          r_bx;
    logic [NPH-1:0][Q_W-1:0] r_bq;

    // Values at the full horizon of the last three stages.
    logic [V_W-1:0] r_v0;
    logic [V_W-1:0] r_v1;
    logic [V_W-1:0] r_v2;

    // Output register.
    logic            r_out_valid;
    logic [PH_W-1:0] r_out_phase;
    logic [G_W-1:0]  r_out_green;
    logic            r_out_last;
    logic            r_out_limit;

    // Decoded configuration.
    logic [PH_W-1:0] w_first_ph;
    logic [3:0]      w_min_green;

    assign w_first_ph  = (i_cfg.start_phase > PH_LAST) ? PH_A : i_cfg.start_phase;
    assign w_min_green = (i_cfg.min_green == '0) ? 4'd1 : i_cfg.min_green;

    // Which phase the candidate serves, and where its sums start.
    logic [NPH-1:0]       w_served;
    logic [NPH-1:0]       w_incl;
    logic [S_W:0]         w_start;
    logic [IDX_W-1:0]     w_kidx;

    always_comb begin
        w_kidx = r_k[IDX_W-1:0];
        w_start = '0;
        for (int p = 0; p < NPH; p++) begin
            w_served[p] = (r_ph == PH_W'(p)) && (r_x != '0);
            w_start     = w_served[p] ? ({1'b0, r_si} + {1'b0, r_x}) : {1'b0, r_si};
            w_incl[p]   = ({1'b0, r_k} >= w_start);
        end
    end

    // Candidate evaluation: queues, delay, stops and max queue.
    logic [NPH-1:0][Q_W-1:0] c_tq;
    logic [ACC_W-1:0]        c_delay;
    logic [ACC_W-1:0]        c_stops;
    logic [Q_W-1:0]          c_maxq;

    always_comb begin
        logic [Q_W-1:0]  qp;
        logic [S_W-1:0]  span;
        logic [T_W-1:0]  tq_raw;
        logic [TD_W-1:0] td;
        c_delay = '0;
        c_stops = '0;
        c_maxq  = '0;
        span    = S_W'(r_s - r_si);
        for (int p = 0; p < NPH; p++) begin
            qp     = (r_j == J_W'(1)) ? '0 : r_rd.queue[p];
            tq_raw = w_served[p] ? T_W'(r_ts[p]) : (T_W'(qp) + T_W'(r_ts[p]));
            c_tq[p] = (tq_raw > T_W'(Q_MAX)) ? Q_MAX : tq_raw[Q_W-1:0];
            td     = w_served[p] ? TD_W'(r_ws[p])
                                 : (TD_W'(qp) * TD_W'(span) + TD_W'(r_ws[p]));
            c_delay = c_delay + ACC_W'(td);
            c_stops = c_stops + ACC_W'(r_ts[p]);
            if (c_tq[p] > c_maxq) begin
                c_maxq = c_tq[p];
            end
        end
    end

    // Objective value and comparison against the best so far.
    logic [ACC_W-1:0] c_val;
    logic [V_W-1:0]   c_val_sat;
    logic [V_W-1:0]   c_prev;
    logic             c_better;

    always_comb begin
        c_prev = (r_j == J_W'(1)) ? '0 : r_rd.value;
        if (i_cfg.index_mode == MODE_MAX_QUEUE) begin
            c_val = (ACC_W'(r_maxq) > ACC_W'(c_prev)) ? ACC_W'(r_maxq) : ACC_W'(c_prev);
        end else if (i_cfg.index_mode == MODE_TOTAL_STOPS) begin
            c_val = r_stops + ACC_W'(c_prev);
        end else begin
            c_val = r_delay + ACC_W'(c_prev);
        end
        c_val_sat = (c_val > ACC_W'(V_MAX)) ? V_MAX : c_val[V_W-1:0];
        c_better  = r_first || (c_val_sat < r_bv);
    end

    // Next candidate green and whether it still fits the state.
    localparam int XC_W = ((S_W > 4) ? S_W : 4) + 2;
    logic [XC_W-1:0] c_nx;
    logic            c_nx_ok;

    assign c_nx    = (r_x == '0) ? XC_W'(w_min_green) : XC_W'(XC_W'(r_x) + 1'b1);
    assign c_nx_ok = (r_j != J_W'(1)) && (XC_W'(c_nx + 2'd2) <= XC_W'(r_s));

    // Stage stop tests.
    logic c_conv;
    logic c_at_limit;

    assign c_conv     = (r_j >= J_W'(3)) && (r_v1 == r_v0) && (r_v2 == r_v0);
    assign c_at_limit = ((J_W + 1)'(r_j) + 1'b1) >= (J_W + 1)'(MAX_STAGES);

    // Output handshake.
    logic w_out_free;

    assign w_out_free = !r_out_valid || o_out.ready;

    // Start state of the candidate being set up.
    logic [S_W-1:0] c_si_next;

    always_comb begin
        if (r_j == J_W'(1)) begin
            c_si_next = '0;
        end else if (r_x == '0) begin
            c_si_next = r_s;
        end else begin
            c_si_next = S_W'(r_s - r_x - 1'b1);
        end
    end

    // Memory port control.
    assign w_rd_en   = (r_state == ST_CAND) || (r_state == ST_RRD);
    assign w_rd_addr = (r_state == ST_RRD) ? {r_jj, r_s}
                                           : {J_W'(r_j - 1'b1), c_si_next};
    assign w_wr_en   = (r_state == ST_WRITE);

    assign o_pop = (r_state == ST_LOAD) && !i_empty;

    // State transitions.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_LOAD: begin
                if (!i_empty && i_beat.last) begin
                    n_state = ST_CAND;
                end
            end
            ST_CAND: begin
                n_state = ST_ACC;
            end
            ST_ACC: begin
                if (r_k >= r_s) begin
                    n_state = ST_EVAL;
                end
            end
            ST_EVAL: begin
                n_state = ST_CMP;
            end
            ST_CMP: begin
                n_state = c_nx_ok ? ST_CAND : ST_WRITE;
            end
            ST_WRITE: begin
                n_state = (r_s == S_W'(HORIZON)) ? ST_CHECK : ST_CAND;
            end
            ST_CHECK: begin
                n_state = (c_conv || c_at_limit) ? ST_RRD : ST_CAND;
            end
            ST_RRD: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (w_out_free) begin
                    n_state = (r_jj == J_W'(1)) ? ST_LOAD : ST_RRD;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_j         <= J_W'(1);
            r_ph        <= PH_LAST;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_LOAD && !i_empty && i_beat.last) begin
                r_j  <= J_W'(1);
                r_ph <= w_first_ph;
            end else if (r_state == ST_CHECK && !c_conv && !c_at_limit) begin
                r_j  <= J_W'(r_j + 1'b1);
                r_ph <= f_next_phase(r_ph);
            end
            if (r_state == ST_EMIT && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Arrival store writes.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_store[i_beat.idx] <= i_beat.arr;
        end
    end

    // Stage table memory.
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[{r_j, r_s}] <= '{choice: r_bx, value: r_bv, queue: r_bq};
        end
        if (w_rd_en) begin
            r_rd <= r_mem[w_rd_addr];
        end
    end

    // Datapath registers of the sequencer.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_LOAD: begin
                r_s     <= S_W'(1);
                r_x     <= '0;
                r_first <= 1'b1;
                r_limit <= 1'b0;
            end
            ST_CAND: begin
                // Set up the sums of one candidate green.
                r_si <= c_si_next;
                r_k  <= c_si_next;
                r_ts <= '0;
                r_ws <= '0;
            end
            ST_ACC: begin
                // One time step of the stage per cycle, all phases at once.
                if (r_k < r_s) begin
                    for (int p = 0; p < NPH; p++) begin
                        if (w_incl[p]) begin
                            r_ts[p] <= SUM_W'(r_ts[p] + SUM_W'(r_store[w_kidx][p]));
                            if (r_store[w_kidx][p] != '0) begin
                                r_ws[p] <= WAIT_W'(r_ws[p] + WAIT_W'(S_W'(r_s - r_k)));
                            end
                        end
                    end
                    r_k <= S_W'(r_k + 1'b1);
                end
            end
            ST_EVAL: begin
                r_tq    <= c_tq;
                r_delay <= c_delay;
                r_stops <= c_stops;
                r_maxq  <= c_maxq;
            end
            ST_CMP: begin
                // The first least value wins.
                if (c_better) begin
                    r_bv <= c_val_sat;
                    r_bx <= r_x;
                    r_bq <= r_tq;
                end
                r_first <= 1'b0;
                if (c_nx_ok) begin
                    r_x <= S_W'(c_nx);
                end
            end
            ST_WRITE: begin
                r_first <= 1'b1;
                if (r_s == S_W'(HORIZON)) begin
                    r_v2 <= r_v1;
                    r_v1 <= r_v0;
                    r_v0 <= r_bv;
                end else begin
                    r_s <= S_W'(r_s + 1'b1);
                    r_x <= (r_j == J_W'(1)) ? r_s : '0;
                end
            end
            ST_CHECK: begin
                if (c_conv || c_at_limit) begin
                    // Retrieval starts two stages back, at the full horizon.
                    r_limit <= !c_conv;
                    r_jj    <= J_W'(r_j - 2'd2);
                    r_s     <= S_W'(HORIZON);
                    r_rph   <= f_next_phase(r_ph);
                end else begin
                    r_s     <= S_W'(1);
                    r_x     <= '0;
                    r_first <= 1'b1;
                end
            end
            ST_RRD: begin
            end
            ST_EMIT: begin
                // Load the output register and step back one stage.
                if (w_out_free) begin
                    r_out_phase <= r_rph;
                    r_out_green <= (r_rd.choice > S_W'(G_MAX)) ? G_MAX
                                                                : G_W'(r_rd.choice);
                    r_out_last  <= (r_jj == J_W'(1));
                    r_out_limit <= r_limit;
                    if (r_jj != J_W'(1)) begin
                        if (r_rd.choice != '0) begin
                            r_s <= S_W'(r_s - r_rd.choice - 1'b1);
                        end
                        r_jj  <= J_W'(r_jj - 1'b1);
                        r_rph <= f_prev_phase(r_rph);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.plan_phase      = r_out_phase;
    assign o_out.green_length    = r_out_green;
    assign o_out.plan_last       = r_out_last;
    assign o_out.stage_limit_hit = r_out_limit;

    // The step walk never passes the end of the state.
    `SPDO_ASSERT_IMPL(a_acc_in_range, i_clk, i_rst_n, r_state == ST_ACC, r_k <= r_s)
    // Candidates are set up only inside a real stage and state.
    `SPDO_ASSERT_IMPL(a_cand_range, i_clk, i_rst_n, r_state == ST_CAND, r_j != '0 && r_s != '0)
    // Retrieval stays on stages that were computed.
    `SPDO_ASSERT_IMPL(a_ret_range, i_clk, i_rst_n, r_state == ST_RRD, r_jj != '0 && r_jj < r_j)
    // An emitted plan entry lands in the output register.
    `SPDO_ASSERT_NEXT(a_emit_loads, i_clk, i_rst_n, r_state == ST_EMIT && w_out_free, r_out_valid)

endmodule

@@ design/signal_phase_dp_optimizer.sv @@
// An arrival beat is taken while the two-entry load queue has room; the back end pops
// the queue only while loading, so beats of the next horizon wait there. After the beat
// that fills the horizon, the stage engine sets up, accumulates, evaluates and compares each
// DP candidate, writes each state and checks each stage; the plan then leaves entry by entry.
// Throughput is set by the single stage engine and the stage table memory.
// Synchronous active-low reset empties the queue, restarts loading, restores control registers.
module signal_phase_dp_optimizer import spdo_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    spdo_in_if.sink              i_in,
    spdo_out_if.source           o_out,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    t_cfg       r_cfg;
    logic       w_push;
    t_load_beat w_push_beat;
    logic       w_full;
    logic       w_pop;
    logic       w_empty;
    t_load_beat w_pop_beat;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_phase <= 2'd2;
            r_cfg.index_mode  <= 2'd2;
            r_cfg.min_green   <= 4'd2;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_START_PHASE: r_cfg.start_phase <= i_cfg_data[1:0];
                CFG_INDEX_MODE:  r_cfg.index_mode  <= i_cfg_data[1:0];
                CFG_MIN_GREEN:   r_cfg.min_green   <= i_cfg_data[3:0];
                default: begin
                end
            endcase
        end
    end

    spdo_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_full      (w_full),
        .o_push      (w_push),
        .o_push_beat (w_push_beat)
    );

    spdo_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_beat (w_push_beat),
        .o_full      (w_full),
        .i_pop       (w_pop),
        .o_empty     (w_empty),
        .o_pop_beat  (w_pop_beat)
    );

    spdo_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_empty (w_empty),
        .i_beat  (w_pop_beat),
        .o_pop   (w_pop),
        .o_out   (o_out)
    );

endmodule

@@ sim/tb_top.sv @@
// Self-checking bench for signal_phase_dp_optimizer: loads random arrival horizons,
// predicts the emitted phase plan and compares it beat by beat.
// Depends on spdo_pkg, the spdo_in_if and spdo_out_if interfaces and the optimizer RTL.
module tb_top;
    import spdo_pkg::*;

    localparam int LIMIT_CYCLES = 900000;
    localparam int DRAIN_CYCLES = 3000;

    typedef struct packed {
        logic [PH_W-1:0] phase;
        logic [G_W-1:0]  green;
        logic            last;
        logic            limit;
    } t_plan_entry;

    // One row of the directed table: arrivals plus an optional typed-in plan head.
    typedef struct {
        logic [7:0]      a;
        logic [7:0]      b;
        logic [7:0]      c;
        bit              has_fixed;
        t_plan_entry     fixed;
    } t_arrival_row;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0] i_cfg_data;

    spdo_in_if  arr_if ();
    spdo_out_if plan_if ();

    signal_phase_dp_optimizer dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (arr_if.sink),
        .o_out     (plan_if.source),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data)
    );

    // Predictor state.
    logic [7:0]  horizon_arr [HORIZON][NPH];
    int unsigned steps_loaded;
    logic [15:0] stage_value [MAX_STAGES][HORIZON+1];
    logic [3:0]  stage_choice [MAX_STAGES][HORIZON+1];
    logic [11:0] stage_queue [MAX_STAGES][HORIZON+1][NPH];
    logic [1:0]  cfg_start;
    logic [1:0]  cfg_mode;
    logic [3:0]  cfg_min_green;

    t_plan_entry plan_expected[$];
    int unsigned errors;
    int unsigned plans_seen;
    int unsigned beats_seen;
    int unsigned cycle_count;
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("tb_top failed");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        errors++;
        $display("MISMATCH at cycle %0d: %s", cycle_count, what);
    endtask

    function automatic int unsigned sum_arrivals(int unsigned a, int unsigned b, int p);
        int unsigned t;
        t = 0;
        for (int k = a; k < b && k < HORIZON; k++) t += horizon_arr[k][p];
        return t;
    endfunction

    function automatic int unsigned sum_wait(int unsigned a, int unsigned b, int p);
        int unsigned t;
        t = 0;
        for (int k = a; k < b && k < HORIZON; k++)
            if (horizon_arr[k][p] != 0) t += b - k;
        return t;
    endfunction

    // Cost of giving green x at state s of stage j; also returns the queues.
    function automatic int unsigned green_cost(int unsigned j, int unsigned ph,
                                               int unsigned s, int unsigned x,
                                               output logic [11:0] q [NPH]);
        int unsigned h, si, maxq, stops, dly, prev, val, qp, tq, ts, td;
        h = (x != 0) ? x + 1 : 0;
        si = (j == 1) ? 0 : s - h;
        maxq = 0; stops = 0; dly = 0;
        for (int p = 0; p < NPH; p++) begin
            qp = (si == 0) ? 0 : stage_queue[j-1][si][p];
            if (p != ph || x == 0) begin
                ts = sum_arrivals(si, s, p);
                tq = qp + ts;
                td = qp * (s - si) + sum_wait(si, s, p);
            end else begin
                ts = sum_arrivals(si + x, s, p);
                tq = ts;
                td = sum_wait(si + x, s, p);
            end
            if (tq > 4095) tq = 4095;
            q[p] = tq[11:0];
            if (tq > maxq) maxq = tq;
            stops += ts;
            dly += td;
        end
        prev = stage_value[j-1][si];
        if (cfg_mode == MODE_MAX_QUEUE) val = (maxq > prev) ? maxq : prev;
        else if (cfg_mode == MODE_TOTAL_STOPS) val = stops + prev;
        else val = dly + prev;
        return (val > 65535) ? 65535 : val;
    endfunction

    task automatic solve_stage(int unsigned j, int unsigned ph);
        logic [11:0] q [NPH];
        logic [11:0] bq [NPH];
        int unsigned v, bv, bx, g;
        g = (cfg_min_green == 0) ? 1 : cfg_min_green;
        for (int unsigned s = 1; s <= HORIZON; s++) begin
            if (j == 1) begin
                bx = s - 1;
                bv = green_cost(j, ph, s, bx, bq);
            end else begin
                bx = 0;
                bv = green_cost(j, ph, s, 0, bq);
                for (int unsigned x = g; x + 2 <= s; x++) begin
                    v = green_cost(j, ph, s, x, q);
                    if (v < bv) begin
                        bv = v;
                        bx = x;
                        bq = q;
                    end
                end
            end
            stage_value[j][s] = bv[15:0];
            stage_choice[j][s] = bx[3:0];
            for (int p = 0; p < NPH; p++) stage_queue[j][s][p] = bq[p];
        end
    endtask

    // Store one step; on a full horizon run the stage search and queue the plan.
    task automatic predict_plan(input logic [7:0] a, input logic [7:0] b, input logic [7:0] c);
        int unsigned first, j, ph, s, x;
        bit limit;
        t_plan_entry e;
        horizon_arr[steps_loaded][0] = a;
        horizon_arr[steps_loaded][1] = b;
        horizon_arr[steps_loaded][2] = c;
        steps_loaded++;
        if (steps_loaded < HORIZON) return;
        steps_loaded = 0;
        first = (cfg_start == 3) ? 0 : cfg_start;
        j = 1;
        ph = first;
        limit = 1'b0;
        forever begin
            solve_stage(j, ph);
            if (j >= 3 && stage_value[j-1][HORIZON] == stage_value[j][HORIZON]
                && stage_value[j-2][HORIZON] == stage_value[j][HORIZON]) break;
            if (j + 1 >= MAX_STAGES) begin
                limit = 1'b1;
                break;
            end
            ph = (ph + 1) % NPH;
            j++;
        end
        s = HORIZON;
        for (int jj = j - 2; jj >= 1; jj--) begin
            x = stage_choice[jj][s];
            e.phase = PH_W'((first + jj - 1) % NPH);
            e.green = G_W'(x);
            e.last = (jj == 1);
            e.limit = limit;
            plan_expected = {plan_expected, e};
            if (jj > 1 && x != 0) s -= x + 1;
        end
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [3:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_START_PHASE: cfg_start = val[1:0];
            CFG_INDEX_MODE:  cfg_mode = val[1:0];
            default:         cfg_min_green = val;
        endcase
    endtask

    // Send one arrival beat, with random idle cycles before it; valid stays up
    // into the next beat unless the sender idles or drains.
    task automatic send_step(input logic [7:0] a, input logic [7:0] b, input logic [7:0] c);
        while ($urandom_range(99, 0) < send_idle_pct) begin
            arr_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        arr_if.valid <= 1'b1;
        arr_if.arrivals_phase_a <= a;
        arr_if.arrivals_phase_b <= b;
        arr_if.arrivals_phase_c <= c;
        @(posedge i_clk);
        while (!arr_if.ready) @(posedge i_clk);
        predict_plan(a, b, c);
        @(negedge i_clk);
    endtask

    // Stop sending and wait until every expected plan beat has come out.
    task automatic wait_drained();
        arr_if.valid <= 1'b0;
        while (plan_expected.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    // Receiver stall and plan checking.
    always @(negedge i_clk) begin
        if (i_rst_n) plan_if.ready <= ($urandom_range(99, 0) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        t_plan_entry got, want;
        if (i_rst_n && plan_if.valid && plan_if.ready) begin
            got = {plan_if.plan_phase, plan_if.green_length, plan_if.plan_last,
                   plan_if.stage_limit_hit};
            beats_seen++;
            if (plan_expected.size() == 0) begin
                report_mismatch($sformatf("unexpected plan beat %h", got));
            end else begin
                want = plan_expected.pop_front();
                if (got.phase !== want.phase)
                    report_mismatch($sformatf("phase %0d want %0d", got.phase, want.phase));
                if (got.green !== want.green)
                    report_mismatch($sformatf("green %0d want %0d", got.green, want.green));
                if (got.last !== want.last)
                    report_mismatch($sformatf("last %0d want %0d", got.last, want.last));
                if (got.limit !== want.limit)
                    report_mismatch($sformatf("limit %0d want %0d", got.limit, want.limit));
                if (want.last) plans_seen++;
            end
        end
    end

    // Directed horizons: zero traffic, then heavy mixed traffic on all three phases.
    t_arrival_row directed [20];

    initial begin
        t_plan_entry fix;
        int unsigned horizons;
        cycle_count = 0;
        errors = 0;
        plans_seen = 0;
        beats_seen = 0;
        steps_loaded = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        cfg_start = 2'd2;
        cfg_mode = 2'd2;
        cfg_min_green = 4'd2;
        for (int s = 0; s < MAX_STAGES; s++)
            for (int k = 0; k <= HORIZON; k++) stage_value[s][k] = '0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_START_PHASE;
        i_cfg_data = '0;
        arr_if.valid = 1'b0;
        arr_if.arrivals_phase_a = '0;
        arr_if.arrivals_phase_b = '0;
        arr_if.arrivals_phase_c = '0;
        plan_if.ready = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Zero horizon: all values agree at once, plan is one skipped-free
        // stage-one entry for the reset start phase (C) with full green.
        fix = '{phase: PH_W'(2), green: G_W'(9), last: 1'b1, limit: 1'b0};
        for (int i = 0; i < 10; i++) directed[i] = '{0, 0, 0, (i == 9), fix};
        for (int i = 10; i < 20; i++)
            directed[i] = '{8'hFF, (i % 2) ? 8'hFF : 8'h00, (i < 15) ? 8'h01 : 8'h80,
                            1'b0, fix};
        foreach (directed[i]) begin
            send_step(directed[i].a, directed[i].b, directed[i].c);
            if (directed[i].has_fixed) begin
                // The typed-in entry must be the whole plan; the DUT is held to it.
                if (plan_expected.size() != 1 || plan_expected[0] !== directed[i].fixed)
                    report_mismatch("zero-traffic plan differs from the typed-in entry");
                wait_drained();
                if (plan_expected.size() == 0 && plans_seen != 1)
                    report_mismatch("zero-traffic horizon gave no single plan");
            end
        end
        wait_drained();

        // Random horizons across register settings, extremes and odd codes.
        for (int phase_i = 0; phase_i < 6; phase_i++) begin
            wait_drained();
            repeat (DRAIN_CYCLES) @(negedge i_clk);
            write_reg(CFG_START_PHASE, 4'($urandom_range(3, 0)));
            write_reg(CFG_INDEX_MODE, 4'(phase_i % 4));
            case (phase_i)
                0: write_reg(CFG_MIN_GREEN, 4'd1);
                1: write_reg(CFG_MIN_GREEN, 4'd10);
                2: write_reg(CFG_MIN_GREEN, 4'd0);
                3: write_reg(CFG_MIN_GREEN, 4'd15);
                default: write_reg(CFG_MIN_GREEN, 4'($urandom_range(15, 0)));
            endcase
            case (phase_i % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 63; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 63; end
                default: begin send_idle_pct = 35; recv_stall_pct = 35; end
            endcase
            horizons = (phase_i < 4) ? 2 : 1;
            for (int h = 0; h < horizons * HORIZON; h++) begin
                case ($urandom_range(3, 0))
                    0: send_step(8'($urandom), 8'($urandom), 8'($urandom));
                    1: send_step(8'($urandom_range(3, 0)), 8'($urandom_range(3, 0)),
                                 8'($urandom_range(3, 0)));
                    2: send_step(8'($urandom_range(1, 0)), 8'd0, 8'($urandom_range(9, 0)));
                    default: send_step(8'hFF, 8'($urandom), 8'd0);
                endcase
            end
        end

        send_idle_pct = 0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        $display("Covered %0d plans (%0d beats) over all objectives, start phases and",
                 plans_seen, beats_seen);
        $display("minimum green extremes, with sender idling and receiver stalls.");
        if (errors == 0 && plan_expected.size() == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end
endmodule
